### src/gsa_pkg.sv
// Shared constants, codes and beat types of the gradient scatter-add core.
package gsa_pkg;

  // Table geometry and number format
  localparam int MAX_ROWS    = 1024;
  localparam int MAX_COLS    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int ENTRY_COUNT = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W      = $clog2(ENTRY_COUNT);

  // Port field widths
  localparam int DATA_W    = 32;
  localparam int KIND_W    = 2;
  localparam int COL_W     = 6;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 11;

  // Configuration register widths
  localparam int PAD_ROW_W = 10;
  localparam int ROWS_W    = 11;
  localparam int COLS_W    = 7;

  // Clear generation tag kept with every table entry
  localparam int EPOCH_W = 8;

  // Queue sizes
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int RESQ_DEPTH = 4;
  localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR = 2'd0,
    KIND_ACC   = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAD_EN    = 2'd0,
    CFG_PAD_ROW   = 2'd1,
    CFG_ROW_COUNT = 2'd2,
    CFG_ROW_WIDTH = 2'd3
  } cfg_idx_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK  = 2'd0,
    STAT_PAD = 2'd1,
    STAT_ROW = 2'd2,
    STAT_COL = 2'd3
  } status_e;

  // Operation handed from front to back
  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_ACC,
    OP_READ,
    OP_DONE
  } op_e;

  typedef enum logic {
    BK_SWEEP,
    BK_RUN
  } bk_state_e;

  typedef struct packed {
    op_e                      op;
    status_e                  status;
    logic [ADDR_W-1:0]        addr;
    logic signed [DATA_W-1:0] grad;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    status_e           status;
    logic              saturated;
  } res_t;

endpackage

### src/gsa_front.sv
// Front end: configuration registers, input range checks and command build.
module gsa_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  output logic                             full_o,
  input  logic [gsa_pkg::KIND_W-1:0]       kind_i,
  input  logic signed [gsa_pkg::DATA_W-1:0] row_id_i,
  input  logic [gsa_pkg::COL_W-1:0]        col_i,
  input  logic signed [gsa_pkg::DATA_W-1:0] grad_value_i,
  input  logic                             cfg_we_i,
  input  logic [gsa_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [gsa_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                             q_full_i,
  input  logic                             busy_i,
  output logic                             q_push_o,
  output gsa_pkg::cmd_t                    q_cmd_o
);
  import gsa_pkg::*;

  logic                 pad_en_q;
  logic [PAD_ROW_W-1:0] pad_row_q;
  logic [ROWS_W-1:0]    row_count_q;
  logic [COLS_W-1:0]    row_width_q;

  logic [ROWS_W-1:0]    rows_eff;
  logic [COLS_W-1:0]    cols_eff;
  logic                 row_out;
  logic                 col_out;
  logic                 pad_hit;
  logic [ADDR_W-1:0]    addr;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_en_q    <= 1'b0;
      pad_row_q   <= '0;
      row_count_q <= ROWS_W'(MAX_ROWS);
      row_width_q <= COLS_W'(MAX_COLS);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PAD_EN:    pad_en_q    <= cfg_wdata_i[0];
        CFG_PAD_ROW:   pad_row_q   <= cfg_wdata_i[PAD_ROW_W-1:0];
        CFG_ROW_COUNT: row_count_q <= cfg_wdata_i[ROWS_W-1:0];
        CFG_ROW_WIDTH: row_width_q <= cfg_wdata_i[COLS_W-1:0];
        default: ;
      endcase
    end
  end

  // Limits clamp to the table size
  assign rows_eff = (row_count_q > ROWS_W'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS) : row_count_q;
  assign cols_eff = (row_width_q > COLS_W'(MAX_COLS)) ? COLS_W'(MAX_COLS) : row_width_q;

  // Range checks; negative ids have the top bits set
  assign row_out = (row_id_i[DATA_W-1:ROWS_W] != '0) ||
                   (row_id_i[ROWS_W-1:0] >= rows_eff);
  assign col_out = ({1'b0, col_i} >= cols_eff);
  assign pad_hit = (kind_i == KIND_ACC) && pad_en_q &&
                   (row_id_i[DATA_W-1:PAD_ROW_W] == '0) &&
                   (row_id_i[PAD_ROW_W-1:0] == pad_row_q);

  // Flat entry address: row times row pitch plus column
  assign addr = ADDR_W'(row_id_i[ROWS_W-1:0]) * ADDR_W'(MAX_COLS) + ADDR_W'(col_i);

  // Classify the beat
  always_comb begin
    q_cmd_o.op     = OP_READ;
    q_cmd_o.status = STAT_OK;
    q_cmd_o.addr   = addr;
    q_cmd_o.grad   = grad_value_i;
    case (kind_e'(kind_i))
      KIND_CLEAR: q_cmd_o.op = OP_CLEAR;
      default: begin
        if (pad_hit) begin
          q_cmd_o.op     = OP_DONE;
          q_cmd_o.status = STAT_PAD;
        end else if (row_out) begin
          q_cmd_o.op     = OP_DONE;
          q_cmd_o.status = STAT_ROW;
        end else if (col_out) begin
          q_cmd_o.op     = OP_DONE;
          q_cmd_o.status = STAT_COL;
        end else if (kind_i == KIND_ACC) begin
          q_cmd_o.op = OP_ACC;
        end else begin
          q_cmd_o.op = OP_READ;
        end
      end
    endcase
  end

  // Input handshake
  assign full_o   = q_full_i | busy_i;
  assign q_push_o = push_i & ~full_o;

endmodule

### src/gsa_cmd_queue.sv
// Command queue that decouples the front end from the table back end.
module gsa_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gsa_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output gsa_pkg::cmd_t data_o,
  output logic          empty_o
);
  import gsa_pkg::*;

  cmd_t                  slot_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMDQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMDQ_PTR_W:0]   cnt_q, cnt_d;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = slot_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("command queue popped while empty");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && full_o && !pop_i |=> 1'b0)
    else $error("command queue written while full");
`endif

endmodule

### src/gsa_back.sv
// Back end: gradient table memory, clear epochs, read-modify-write, result buffer.
module gsa_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_empty_i,
  input  gsa_pkg::cmd_t                  q_cmd_i,
  output logic                           q_pop_o,
  output logic                           busy_o,
  output logic                           empty_o,
  input  logic                           pop_i,
  output logic [gsa_pkg::DATA_W-1:0]     value_o,
  output logic [gsa_pkg::STATUS_W-1:0]   status_o,
  output logic                           saturated_o
);
  import gsa_pkg::*;

  localparam int TAG_W = EPOCH_W + VALUE_WIDTH;
  localparam logic [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  // Table memory: each entry holds its clear epoch and its value
  logic [TAG_W-1:0] mem [ENTRY_COUNT];
  logic [TAG_W-1:0] rd_q;
  logic             mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [TAG_W-1:0] mem_wdata;

  bk_state_e         state_q, state_d;
  logic [ADDR_W-1:0] sweep_cnt_q, sweep_cnt_d;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic              sweep_wr;

  logic              b_valid_q;
  cmd_t              b_cmd_q;

  logic                     fwd_valid_q, fwd_valid_d;
  logic [ADDR_W-1:0]        fwd_addr_q, fwd_addr_d;
  logic [VALUE_WIDTH-1:0]   fwd_val_q, fwd_val_d;

  res_t                  res_q [RESQ_DEPTH];
  logic [RESQ_PTR_W-1:0] res_wptr_q, res_rptr_q;
  logic [RESQ_PTR_W:0]   res_cnt_q, res_cnt_d;
  logic                  res_push, res_pop;
  res_t                  res_new;

  logic                          credit;
  logic                          clear_now;
  logic                          wrap;
  logic                          acc_wr;
  logic                          fwd_hit;
  logic [VALUE_WIDTH-1:0]        cur;
  logic signed [VALUE_WIDTH-1:0] grad_ext;
  logic [VALUE_WIDTH:0]          sum_w;
  logic                          sat;
  logic [VALUE_WIDTH-1:0]        sum;

  // Room in the result buffer for the beat in flight plus one more
  assign credit  = ({1'b0, res_cnt_q} + (RESQ_PTR_W+2)'(b_valid_q)) <
                   (RESQ_PTR_W+2)'(RESQ_DEPTH);
  assign q_pop_o = (state_q == BK_RUN) && !q_empty_i && credit &&
                   !(b_valid_q && (b_cmd_q.op == OP_CLEAR));

  // Memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (q_pop_o) begin
      rd_q <= mem[q_cmd_i.addr];
    end
  end

  // Execute stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= q_pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      b_cmd_q <= q_cmd_i;
    end
  end

  // Current entry value: forwarded, or stored from this epoch, or zero
  assign fwd_hit = fwd_valid_q && (fwd_addr_q == b_cmd_q.addr);
  assign cur     = fwd_hit ? fwd_val_q :
                   (rd_q[TAG_W-1:VALUE_WIDTH] == epoch_q) ? rd_q[VALUE_WIDTH-1:0] : '0;

  // Saturating add
  assign grad_ext = VALUE_WIDTH'(b_cmd_q.grad);
  assign sum_w    = {cur[VALUE_WIDTH-1], cur} +
                    {grad_ext[VALUE_WIDTH-1], grad_ext};
  assign sat      = sum_w[VALUE_WIDTH] != sum_w[VALUE_WIDTH-1];
  assign sum      = sat ? (sum_w[VALUE_WIDTH] ? VAL_MIN : VAL_MAX) : sum_w[VALUE_WIDTH-1:0];

  assign clear_now = b_valid_q && (b_cmd_q.op == OP_CLEAR);
  assign wrap      = clear_now && (epoch_q == {EPOCH_W{1'b1}});
  assign acc_wr    = b_valid_q && (b_cmd_q.op == OP_ACC);

  // Result of the beat in the execute stage
  always_comb begin
    res_new.value     = '0;
    res_new.status    = STAT_OK;
    res_new.saturated = 1'b0;
    case (b_cmd_q.op)
      OP_ACC: begin
        res_new.value     = sum[DATA_W-1:0];
        res_new.saturated = sat;
      end
      OP_READ:  res_new.value  = cur[DATA_W-1:0];
      OP_DONE:  res_new.status = b_cmd_q.status;
      default: ;
    endcase
  end

  // Sweep sequencer: next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_SWEEP: if (sweep_cnt_q == {ADDR_W{1'b1}}) state_d = BK_RUN;
      BK_RUN:   if (wrap) state_d = BK_SWEEP;
      default:  state_d = BK_RUN;
    endcase
  end

  // Sweep sequencer: outputs
  always_comb begin
    sweep_wr    = 1'b0;
    busy_o      = 1'b0;
    sweep_cnt_d = '0;
    case (state_q)
      BK_SWEEP: begin
        sweep_wr    = 1'b1;
        busy_o      = 1'b1;
        sweep_cnt_d = sweep_cnt_q + 1'b1;
      end
      default: ;
    endcase
  end

  // Write port select
  assign mem_we    = sweep_wr | acc_wr;
  assign mem_waddr = sweep_wr ? sweep_cnt_q : b_cmd_q.addr;
  assign mem_wdata = sweep_wr ? '0 : {epoch_q, sum};

  // Epoch and forwarding register
  always_comb begin
    epoch_d     = epoch_q;
    fwd_valid_d = fwd_valid_q;
    fwd_addr_d  = fwd_addr_q;
    fwd_val_d   = fwd_val_q;
    if (wrap) begin
      epoch_d = EPOCH_W'(1);
    end else if (clear_now) begin
      epoch_d = epoch_q + 1'b1;
    end
    if (clear_now) begin
      fwd_valid_d = 1'b0;
    end else if (acc_wr) begin
      fwd_valid_d = 1'b1;
      fwd_addr_d  = b_cmd_q.addr;
      fwd_val_d   = sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_SWEEP;
      sweep_cnt_q <= '0;
      epoch_q     <= EPOCH_W'(1);
      fwd_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_cnt_q <= sweep_cnt_d;
      epoch_q     <= epoch_d;
      fwd_valid_q <= fwd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_addr_q <= fwd_addr_d;
    fwd_val_q  <= fwd_val_d;
  end

  // Result buffer
  assign res_push = b_valid_q;
  assign res_pop  = pop_i && !empty_o;

  always_comb begin
    res_cnt_d = res_cnt_q;
    if (res_push && !res_pop) begin
      res_cnt_d = res_cnt_q + 1'b1;
    end else if (!res_push && res_pop) begin
      res_cnt_d = res_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wptr_q <= '0;
      res_rptr_q <= '0;
      res_cnt_q  <= '0;
    end else begin
      if (res_push) res_wptr_q <= res_wptr_q + 1'b1;
      if (res_pop)  res_rptr_q <= res_rptr_q + 1'b1;
      res_cnt_q <= res_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_q[res_wptr_q] <= res_new;
    end
  end

  assign empty_o     = (res_cnt_q == '0);
  assign value_o     = res_q[res_rptr_q].value;
  assign status_o    = res_q[res_rptr_q].status;
  assign saturated_o = res_q[res_rptr_q].saturated;

`ifndef SYNTHESIS
  a_sweep_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_SWEEP) |-> (!b_valid_q && !q_pop_o))
    else $error("table access during clearing sweep");

  a_clear_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_now |=> !b_valid_q)
    else $error("beat issued right behind a clear");

  a_epoch_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_RUN) |-> (epoch_q != '0))
    else $error("live epoch matches swept tag");

  a_res_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_q <= (RESQ_PTR_W+1)'(RESQ_DEPTH))
    else $error("result buffer overflow");
`endif

endmodule

### src/embedding_gradient_scatter_add_core.sv
// Top level of the embedding gradient scatter-add core.
// Path: command queue, execute stage register, then the result buffer.
// Throughput: one beat per cycle unless stalled; a clear delays the next beat.
// Memory port: one table read and one write per cycle; hits forwarded.
// Reset: sweep clears all 65536 entries (full high); every 255th clear repeats it.
module embedding_gradient_scatter_add_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic [gsa_pkg::KIND_W-1:0]        kind_i,
  input  logic signed [gsa_pkg::DATA_W-1:0] row_id_i,
  input  logic [gsa_pkg::COL_W-1:0]         col_i,
  input  logic signed [gsa_pkg::DATA_W-1:0] grad_value_i,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [gsa_pkg::DATA_W-1:0] value_o,
  output logic [gsa_pkg::STATUS_W-1:0]      status_o,
  output logic                              saturated_o,
  input  logic                              cfg_we_i,
  input  logic [gsa_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [gsa_pkg::CFG_W-1:0]         cfg_wdata_i
);
  import gsa_pkg::*;

  logic              q_push, q_full, q_pop, q_empty, busy;
  cmd_t              q_in, q_out;
  logic [DATA_W-1:0] value_raw;

  // Accept and classify
  gsa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .kind_i       (kind_i),
    .row_id_i     (row_id_i),
    .col_i        (col_i),
    .grad_value_i (grad_value_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .q_full_i     (q_full),
    .busy_i       (busy),
    .q_push_o     (q_push),
    .q_cmd_o      (q_in)
  );

  // Decoupling queue
  gsa_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  // Table execution and results
  gsa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_cmd_i     (q_out),
    .q_pop_o     (q_pop),
    .busy_o      (busy),
    .empty_o     (empty),
    .pop_i       (pop),
    .value_o     (value_raw),
    .status_o    (status_o),
    .saturated_o (saturated_o)
  );

  assign value_o = signed'(value_raw);

endmodule
